// ----- hdl/iee_pkg.sv -----
// ----------------------------------------------------------------------------
// iee_pkg
// Shared types, character codes and decode helpers for the infix expression
// evaluator.
// ----------------------------------------------------------------------------
package iee_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int OUT_WIDTH       = 64;
  localparam int CHAR_WIDTH      = 8;

  localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [CHAR_WIDTH-1:0] CH_STAR  = 8'h2A;  // '*'
  localparam logic [CHAR_WIDTH-1:0] CH_SLASH = 8'h2F;  // '/'
  localparam logic [CHAR_WIDTH-1:0] CH_EQUAL = 8'h3D;  // '='

  // Operator before the current number. Code 3 is never written.
  typedef enum logic [1:0] {
    PM_NONE = 2'd0,
    PM_MUL  = 2'd1,
    PM_DIV  = 2'd2
  } pmul_t;

  typedef enum logic [2:0] {
    OP_MUL = 3'd0,
    OP_DIV = 3'd1,
    OP_ADD = 3'd2,
    OP_SUB = 3'd3,
    OP_EQ  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    CC_DIGIT = 2'd0,
    CC_OP    = 2'd1,
    CC_OTHER = 2'd2
  } cls_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_FIN  = 2'd2
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic digit;        // shift a decimal digit into the number
    logic num_plain;    // term <= number
    logic num_zero_div; // divide by zero: term <= 0, flag error
    logic mdu_start;    // launch the iterative multiply/divide unit
    logic mdu_div;      // launched operation is a divide
    logic finish;       // apply the operator in op
    op_t  op;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    pmul_t pmul;
    logic  num_zero;
    logic  mdu_done;
  } sts_t;

  function automatic cls_t char_class(input logic [CHAR_WIDTH-1:0] ch);
    cls_t c;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      c = CC_DIGIT;
    end else if (ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR ||
                 ch == CH_SLASH || ch == CH_EQUAL) begin
      c = CC_OP;
    end else begin
      c = CC_OTHER;
    end
    return c;
  endfunction

  function automatic op_t char_op(input logic [CHAR_WIDTH-1:0] ch);
    op_t o;
    priority if (ch == CH_STAR) begin
      o = OP_MUL;
    end else if (ch == CH_SLASH) begin
      o = OP_DIV;
    end else if (ch == CH_PLUS) begin
      o = OP_ADD;
    end else if (ch == CH_MINUS) begin
      o = OP_SUB;
    end else begin
      o = OP_EQ;
    end
    return o;
  endfunction

endpackage

// ----- hdl/iee_mdu.sv -----
// ----------------------------------------------------------------------------
// iee_mdu
// Shared iterative unit: shift-add multiply (wrapping) or restoring signed
// divide (truncating), one bit per cycle.
// ----------------------------------------------------------------------------
module iee_mdu #(
  parameter int W = iee_pkg::VALUE_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic         is_div,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         done,
  output logic [W-1:0] res
);

  localparam int CW = $clog2(W);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          div_r, div_nxt;
  logic          neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  acc_r, acc_nxt;  // product / partial remainder
  logic [W-1:0]  x_r, x_nxt;      // multiplicand / dividend-quotient shifter
  logic [W-1:0]  y_r, y_nxt;      // multiplier / divisor magnitude
  logic [W-1:0]  shl;
  logic          ge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    div_r <= div_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
  end

  // Remainder stays below the divisor magnitude, so the shifted value fits W bits
  assign shl = {acc_r[W-2:0], x_r[W-1]};
  assign ge  = (shl >= y_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W - 1);
      div_nxt  = is_div;
      acc_nxt  = '0;
      if (is_div) begin
        neg_nxt = a[W-1] ^ b[W-1];
        x_nxt   = a[W-1] ? (W'(0) - a) : a;
        y_nxt   = b[W-1] ? (W'(0) - b) : b;
      end else begin
        neg_nxt = 1'b0;
        x_nxt   = a;
        y_nxt   = b;
      end
    end else if (busy_r) begin
      if (div_r) begin
        acc_nxt = ge ? (shl - y_r) : shl;
        x_nxt   = {x_r[W-2:0], ge};
      end else begin
        acc_nxt = acc_r + (y_r[0] ? x_r : '0);
        x_nxt   = {x_r[W-2:0], 1'b0};
        y_nxt   = {1'b0, y_r[W-1:1]};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign done = done_r;
  assign res  = div_r ? (neg_r ? (W'(0) - x_r) : x_r) : acc_r;

endmodule

// ----- hdl/iee_dp.sv -----
// ----------------------------------------------------------------------------
// iee_dp
// Datapath: running sum, term, number being read, pending operators, error
// flag and the result register. Acts only on controller commands.
// ----------------------------------------------------------------------------
module iee_dp #(
  parameter int W = iee_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [iee_pkg::CHAR_WIDTH-1:0]  in_char_code,
  input  iee_pkg::cmd_t                   cmd,
  output iee_pkg::sts_t                   sts,
  output logic signed [iee_pkg::OUT_WIDTH-1:0] out_value,
  output logic                            out_div_zero
);

  logic [W-1:0]           sum_r, sum_nxt;
  logic [W-1:0]           term_r, term_nxt;
  logic [W-1:0]           num_r, num_nxt;
  logic                   padd_r, padd_nxt;
  iee_pkg::pmul_t         pmul_r, pmul_nxt;
  logic                   err_r, err_nxt;
  logic [iee_pkg::OUT_WIDTH-1:0] oval_r, oval_nxt;
  logic                   odz_r, odz_nxt;
  logic [W-1:0]           sum_new;
  logic [3:0]             digit;
  logic                   mdu_done;
  logic [W-1:0]           mdu_res;

  iee_mdu #(.W(W)) u_mdu (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.mdu_start),
    .is_div (cmd.mdu_div),
    .a      (term_r),
    .b      (num_r),
    .done   (mdu_done),
    .res    (mdu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      term_r <= '0;
      num_r  <= '0;
      padd_r <= 1'b0;
      pmul_r <= iee_pkg::PM_NONE;
      err_r  <= 1'b0;
    end else begin
      sum_r  <= sum_nxt;
      term_r <= term_nxt;
      num_r  <= num_nxt;
      padd_r <= padd_nxt;
      pmul_r <= pmul_nxt;
      err_r  <= err_nxt;
    end
    oval_r <= oval_nxt;
    odz_r  <= odz_nxt;
  end

  assign digit   = 4'(in_char_code - iee_pkg::CH_ZERO);
  assign sum_new = padd_r ? (sum_r - term_r) : (sum_r + term_r);

  always_comb begin
    sum_nxt  = sum_r;
    term_nxt = term_r;
    num_nxt  = num_r;
    padd_nxt = padd_r;
    pmul_nxt = pmul_r;
    err_nxt  = err_r;
    oval_nxt = oval_r;
    odz_nxt  = odz_r;
    if (cmd.digit) begin
      num_nxt = (num_r << 3) + (num_r << 1) + W'(digit);
    end
    if (cmd.num_plain) begin
      term_nxt = num_r;
      num_nxt  = '0;
    end
    if (cmd.num_zero_div) begin
      term_nxt = '0;
      err_nxt  = 1'b1;
      num_nxt  = '0;
    end
    if (cmd.mdu_start) begin
      num_nxt = '0;
    end
    if (mdu_done) begin
      term_nxt = mdu_res;
    end
    if (cmd.finish) begin
      unique case (cmd.op)
        iee_pkg::OP_MUL: pmul_nxt = iee_pkg::PM_MUL;
        iee_pkg::OP_DIV: pmul_nxt = iee_pkg::PM_DIV;
        iee_pkg::OP_ADD, iee_pkg::OP_SUB: begin
          sum_nxt  = sum_new;
          term_nxt = '0;
          padd_nxt = (cmd.op == iee_pkg::OP_SUB);
          pmul_nxt = iee_pkg::PM_NONE;
        end
        iee_pkg::OP_EQ: begin
          oval_nxt = iee_pkg::OUT_WIDTH'($signed(sum_new));
          odz_nxt  = err_r;
          sum_nxt  = '0;
          term_nxt = '0;
          num_nxt  = '0;
          padd_nxt = 1'b0;
          pmul_nxt = iee_pkg::PM_NONE;
          err_nxt  = 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign sts.pmul     = pmul_r;
  assign sts.num_zero = (num_r == '0);
  assign sts.mdu_done = mdu_done;

  assign out_value    = oval_r;
  assign out_div_zero = odz_r;

endmodule

// ----- hdl/iee_ctrl.sv -----
// ----------------------------------------------------------------------------
// iee_ctrl
// Controller: decodes each character, sequences number close, the
// multiply/divide unit and operator finish, and owns the result valid.
// ----------------------------------------------------------------------------
module iee_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [iee_pkg::CHAR_WIDTH-1:0] in_char_code,
  output logic                           out_valid,
  input  logic                           out_ready,
  input  iee_pkg::sts_t                  sts,
  output iee_pkg::cmd_t                  cmd
);

  iee_pkg::state_t state_r, state_nxt;
  iee_pkg::op_t    op_r, op_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iee_pkg::ST_IDLE;
      op_r        <= iee_pkg::OP_ADD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result register still holds an untaken transaction
  assign out_busy = out_valid_r && !out_ready;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    out_valid_nxt = out_busy;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.op        = op_r;
    unique case (state_r)
      iee_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (iee_pkg::char_class(in_char_code))
            iee_pkg::CC_DIGIT: cmd.digit = 1'b1;
            iee_pkg::CC_OP: begin
              op_nxt = iee_pkg::char_op(in_char_code);
              unique case (sts.pmul)
                iee_pkg::PM_MUL: begin
                  cmd.mdu_start = 1'b1;
                  state_nxt     = iee_pkg::ST_RUN;
                end
                iee_pkg::PM_DIV: begin
                  if (sts.num_zero) begin
                    cmd.num_zero_div = 1'b1;
                    state_nxt        = iee_pkg::ST_FIN;
                  end else begin
                    cmd.mdu_start = 1'b1;
                    cmd.mdu_div   = 1'b1;
                    state_nxt     = iee_pkg::ST_RUN;
                  end
                end
                default: begin
                  cmd.num_plain = 1'b1;
                  state_nxt     = iee_pkg::ST_FIN;
                end
              endcase
            end
            default: ;
          endcase
        end
      end
      iee_pkg::ST_RUN: begin
        if (sts.mdu_done) begin
          state_nxt = iee_pkg::ST_FIN;
        end
      end
      iee_pkg::ST_FIN: begin
        // '=' waits here until the result register is free
        if (!(op_r == iee_pkg::OP_EQ && out_busy)) begin
          cmd.finish = 1'b1;
          state_nxt  = iee_pkg::ST_IDLE;
          if (op_r == iee_pkg::OP_EQ) begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      default: state_nxt = iee_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hdl/infix_expression_evaluator.sv -----
// ----------------------------------------------------------------------------
// infix_expression_evaluator
// Sequencing: a digit or ignored character is taken in ST_IDLE; an operator or '='
//   passes through ST_FIN when no * or / is pending or a / meets a zero divisor, and
//   through ST_RUN then ST_FIN with a pending * or /, while the bit-serial
//   multiply/divide unit works (one bit per cycle). out_valid is registered in ST_FIN;
//   '=' holds while the output register is full. One character in flight.
// Reset (rst_n low, synchronous) clears sum, term, number, operators, flag.
// ----------------------------------------------------------------------------
module infix_expression_evaluator #(
  parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [iee_pkg::CHAR_WIDTH-1:0]        in_char_code,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [iee_pkg::OUT_WIDTH-1:0]  out_value,
  output logic                                  out_div_zero
);

  iee_pkg::cmd_t cmd;
  iee_pkg::sts_t sts;

  iee_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  iee_dp #(.W(VALUE_WIDTH)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_char_code (in_char_code),
    .cmd          (cmd),
    .sts          (sts),
    .out_value    (out_value),
    .out_div_zero (out_div_zero)
  );

  // Starting the shared unit blocks new input
  a_start_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mdu_start |=> !in_ready)
    else $error("input accepted while multiply/divide unit started");

  // A result is never written over an untaken one
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && cmd.op == iee_pkg::OP_EQ) |-> !(out_valid && !out_ready))
    else $error("result overwritten before it was taken");

  // At most one datapath action per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.digit, cmd.num_plain, cmd.num_zero_div, cmd.mdu_start, cmd.finish}))
    else $error("conflicting datapath commands");

endmodule

// ----- tb/sv/infix_expression_evaluator_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_expression_evaluator_checker
// Passive checker. It watches the character and result channels, keeps its
// own model of the evaluator, queues the value each '=' should produce and
// compares every result transaction against the oldest one queued.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_checker #(
  parameter int VW = iee_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic [iee_pkg::CHAR_WIDTH-1:0]       in_char_code,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [iee_pkg::OUT_WIDTH-1:0] out_value,
  input  logic                                 out_div_zero,
  output int                                   due_count,
  output int                                   fail_count,
  output int                                   results_checked
);
  import iee_pkg::*;

  typedef struct {
    logic signed [OUT_WIDTH-1:0] value;
    logic                        div_zero;
  } expr_result_t;

  expr_result_t  results_due[$];

  logic [VW-1:0] sum_acc;
  logic [VW-1:0] term_acc;
  logic [VW-1:0] num_acc;
  logic          subtract_term;
  pmul_t         mul_op;
  logic          zero_div_seen;
  int            errors;
  int            checked;

  task automatic report_mismatch(input string msg);
    $display("%0t ns  MISMATCH: %s", $time, msg);
    errors++;
  endtask

  // Signed division truncating toward zero, done on magnitudes so that the
  // most negative value over minus one wraps instead of trapping.
  function automatic logic [VW-1:0] quotient_trunc(input logic [VW-1:0] a,
                                                   input logic [VW-1:0] b);
    logic [VW-1:0] mag_a;
    logic [VW-1:0] mag_b;
    logic [VW-1:0] q;
    mag_a = a[VW-1] ? -a : a;
    mag_b = b[VW-1] ? -b : b;
    q = mag_a / mag_b;
    if (a[VW-1] != b[VW-1]) begin
      q = -q;
    end
    return q;
  endfunction

  task automatic clear_state();
    sum_acc       = '0;
    term_acc      = '0;
    num_acc       = '0;
    subtract_term = 1'b0;
    mul_op        = PM_NONE;
    zero_div_seen = 1'b0;
  endtask

  task automatic fold_number();
    case (mul_op)
      PM_MUL: begin
        term_acc = term_acc * num_acc;
      end
      PM_DIV: begin
        if (num_acc == '0) begin
          term_acc      = '0;
          zero_div_seen = 1'b1;
        end else begin
          term_acc = quotient_trunc(term_acc, num_acc);
        end
      end
      default: begin
        term_acc = num_acc;
      end
    endcase
    num_acc = '0;
  endtask

  task automatic fold_term();
    if (subtract_term) begin
      sum_acc = sum_acc - term_acc;
    end else begin
      sum_acc = sum_acc + term_acc;
    end
    term_acc = '0;
  endtask

  task automatic eval_char(input logic [CHAR_WIDTH-1:0] ch);
    expr_result_t r;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      num_acc = num_acc * 10 + (ch - CH_ZERO);
    end else if (ch == CH_STAR || ch == CH_SLASH) begin
      fold_number();
      mul_op = (ch == CH_STAR) ? PM_MUL : PM_DIV;
    end else if (ch == CH_PLUS || ch == CH_MINUS) begin
      fold_number();
      fold_term();
      subtract_term = (ch == CH_MINUS);
      mul_op        = PM_NONE;
    end else if (ch == CH_EQUAL) begin
      fold_number();
      fold_term();
      r.value    = $signed(sum_acc);
      r.div_zero = zero_div_seen;
      results_due.push_back(r);
      clear_state();
    end
  endtask

  always @(posedge clk) begin
    expr_result_t want;
    if (!rst_n) begin
      clear_state();
      results_due.delete();
      errors  = 0;
      checked = 0;
    end else begin
      // result side first: a result leaving at this edge was queued earlier
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result transaction value=%0d div_zero=%b",
                                    out_value, out_div_zero));
        end else begin
          want = results_due.pop_front();
          if (out_value !== want.value) begin
            report_mismatch($sformatf("value got %0d expected %0d", out_value, want.value));
          end
          if (out_div_zero !== want.div_zero) begin
            report_mismatch($sformatf("div_zero got %b expected %b (value %0d)",
                                      out_div_zero, want.div_zero, want.value));
          end
          checked++;
        end
      end
      if (in_valid && in_ready) begin
        eval_char(in_char_code);
      end
    end
    due_count       <= results_due.size();
    fail_count      <= errors;
    results_checked <= checked;
  end

endmodule

// ----- tb/sv/tb_infix_expression_evaluator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_infix_expression_evaluator
// Stimulus and verdict for the infix expression evaluator. Sends a short
// directed text, then random expressions (mostly well formed, some noise and
// broken sequences) under three sender/receiver idle mixes; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_infix_expression_evaluator;
  import iee_pkg::*;

  localparam int                    VW           = VALUE_WIDTH_DEF;
  localparam int                    RANDOM_ITEMS = 1820;
  localparam int                    STALL_LIMIT  = 4000;
  localparam logic [CHAR_WIDTH-1:0] CH_SPACE     = 8'h20;

  typedef logic [CHAR_WIDTH-1:0] char_q_t[$];

  logic                         clk          = 1'b0;
  logic                         rst_n        = 1'b0;
  logic                         in_valid     = 1'b0;
  logic                         in_ready;
  logic [CHAR_WIDTH-1:0]        in_char_code = '0;
  logic                         out_valid;
  logic                         out_ready    = 1'b0;
  logic signed [OUT_WIDTH-1:0]  out_value;
  logic                         out_div_zero;

  int      due_count;
  int      fail_count;
  int      results_checked;
  int      tx_idle_pct = 0;
  int      rx_idle_pct = 0;
  int      chars_sent  = 0;
  int      items_sent  = 0;
  int      stall_cycles = 0;
  char_q_t expr_text;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  infix_expression_evaluator #(
    .VALUE_WIDTH (VW)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .out_div_zero (out_div_zero)
  );

  infix_expression_evaluator_checker #(
    .VW (VW)
  ) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_code    (in_char_code),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value),
    .out_div_zero    (out_div_zero),
    .due_count       (due_count),
    .fail_count      (fail_count),
    .results_checked (results_checked)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("watchdog: no transaction for %0d cycles, %0d results still due",
             STALL_LIMIT, due_count);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_char(input logic [CHAR_WIDTH-1:0] ch);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= ch;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    chars_sent++;
    if (char_class(ch) != CC_OTHER) begin
      items_sent++;
    end
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i]);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic push_decimal(input logic [63:0] v);
    char_q_t digits;
    do begin
      digits.push_front(CHAR_WIDTH'(CH_ZERO + v % 10));
      v = v / 10;
    end while (v != 0);
    expr_text = {expr_text, digits};
  endtask

  // Mostly short numbers; some full-width, wrap-prone and overlong ones.
  task automatic push_operand();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      push_decimal($urandom_range(0, 99));
    end else if (r < 75) begin
      push_decimal($urandom_range(0, 9999));
    end else if (r < 85) begin
      push_decimal({$urandom, $urandom});
    end else if (r < 89) begin
      push_decimal(64'h8000_0000_0000_0000);
    end else if (r < 93) begin
      push_decimal('1);
    end else if (r < 97) begin
      push_decimal(0);
    end else begin
      repeat ($urandom_range(21, 25)) begin
        expr_text.push_back(CHAR_WIDTH'(CH_ZERO + $urandom_range(0, 9)));
      end
    end
  endtask

  task automatic push_noise();
    logic [CHAR_WIDTH-1:0] ch;
    ch = $urandom_range(0, 255);
    if (char_class(ch) != CC_OTHER) begin
      ch = CH_SPACE;
    end
    expr_text.push_back(ch);
  endtask

  task automatic build_expression();
    int unsigned           shape;
    int unsigned           terms;
    int unsigned           r;
    logic [CHAR_WIDTH-1:0] op;
    expr_text.delete();
    op    = CH_PLUS;
    shape = $urandom_range(0, 99);
    if (shape < 4) begin
      // most negative term over a number that wraps to minus one
      push_decimal(64'h8000_0000_0000_0000);
      expr_text.push_back(CH_SLASH);
      push_decimal('1);
      if (shape < 2) begin
        expr_text.push_back(CH_PLUS);
        push_decimal($urandom_range(0, 9));
      end
      expr_text.push_back(CH_EQUAL);
    end else if (shape < 88) begin
      terms = $urandom_range(1, 6);
      if ($urandom_range(0, 9) == 0) begin
        expr_text.push_back(CH_MINUS);
      end
      for (int i = 0; i < terms; i++) begin
        if (i > 0) begin
          case ($urandom_range(0, 3))
            0: op = CH_PLUS;
            1: op = CH_MINUS;
            2: op = CH_STAR;
            default: op = CH_SLASH;
          endcase
          expr_text.push_back(op);
          if ($urandom_range(0, 99) < 10) begin
            push_noise();
          end
        end
        // a few operands are left out on purpose
        if ($urandom_range(0, 99) >= 3) begin
          if (op == CH_SLASH && $urandom_range(0, 99) < 15) begin
            push_decimal(0);
          end else begin
            push_operand();
          end
        end
        if ($urandom_range(0, 99) < 10) begin
          push_noise();
        end
      end
      expr_text.push_back(CH_EQUAL);
    end else begin
      repeat ($urandom_range(1, 12)) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          case ($urandom_range(0, 4))
            0: expr_text.push_back(CH_PLUS);
            1: expr_text.push_back(CH_MINUS);
            2: expr_text.push_back(CH_STAR);
            3: expr_text.push_back(CH_SLASH);
            default: expr_text.push_back(CH_EQUAL);
          endcase
        end else if (r < 70) begin
          expr_text.push_back(CHAR_WIDTH'(CH_ZERO + $urandom_range(0, 9)));
        end else begin
          expr_text.push_back(CHAR_WIDTH'($urandom_range(0, 255)));
        end
      end
      if ($urandom_range(0, 9) < 7) begin
        expr_text.push_back(CH_EQUAL);
      end
    end
  endtask

  initial begin
    int phase_goal;
    int exprs_in_phase;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: byte extremes, ignored chars, divide by zero, leading minus,
    // operators with missing numbers, precedence
    send_char(8'h00);
    send_string(" 7/0=");
    send_string("-");
    send_char(8'hFF);
    send_string("5*3=");
    send_string("*+/=");
    send_string("12+34*5-6/4=");

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 20;
          rx_idle_pct = 81;
        end
        1: begin
          tx_idle_pct = 81;
          rx_idle_pct = 20;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      phase_goal     = chars_sent + RANDOM_ITEMS / 3;
      exprs_in_phase = 0;
      while (chars_sent < phase_goal) begin
        build_expression();
        foreach (expr_text[i]) begin
          send_char(expr_text[i]);
        end
        exprs_in_phase++;
        // hold the sender off until the result side is empty
        if (exprs_in_phase % 25 == 5) begin
          drain_results();
        end
      end
    end

    drain_results();
    repeat (VW + 16) @(posedge clk);

    $display("Summary: %0d characters sent (%0d digits/operators), %0d results checked",
             chars_sent, items_sent, results_checked);
    $display("Summary: idle mixes sender-heavy, receiver-heavy and none; ",
             "wrap, divide-by-zero and noise cases included");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
